// ===== sv/ihtq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihtq_pkg
// Shared types and constants of the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
package ihtq_pkg;

    localparam int HEAP_DEPTH_DEF = 16;
    localparam int KEY_BITS_DEF   = 48;
    localparam int NUM_HANDLES    = 16;
    localparam int HANDLE_BITS    = 4;
    localparam int TIME_BITS      = 48;
    localparam int BATCH_BITS     = 5;
    localparam int MAX_BATCH      = 16;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_ERASE = 2'd1,
        OP_POP   = 2'd2,
        OP_PEEK  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NONE   = 2'd1,
        ST_FULL   = 2'd2,
        ST_HANDLE = 2'd3
    } status_t;

    localparam logic [2:0] ADDR_BATCH = 3'd0;

    typedef struct packed {
        op_t                    op;
        logic [HANDLE_BITS-1:0] handle;
        logic [TIME_BITS-1:0]   deadline;
        logic [TIME_BITS-1:0]   cut;
    } cmd_t;

endpackage
`default_nettype wire

// ===== sv/indexed_min_heap_timer_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue
// Indexed binary min-heap of timer deadlines with push, erase, peek, pop.
// ----------------------------------------------------------------------------
// A word on the slave stream carries one command (tuser: 0 push, 1 erase by
// handle, 2 pop expired, 3 peek earliest). Every command answers with one
// master word, except a pop expired that removes entries: it returns one word
// per removed entry, earliest first, up to batch_limit of them; tlast marks
// the final word of each command. Commands go into a two-deep queue, so the
// slave side keeps taking words while the heap engine works, until the queue
// is full. The engine runs one command at a time over an entry RAM with one
// write port, one read port and registered reads. Empty slots need no
// clearing after reset: handle presence lives in per-handle valid bits.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue
    import ihtq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,   // timer_handle[3:0], deadline[51:4], cut_time[99:52]
    input  wire logic [1:0]   s_tuser,   // func
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [55:0]       m_tdata,   // out_handle[3:0], out_deadline[51:4]
    output logic [1:0]        m_tuser,   // status
    output logic              m_tlast,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    logic [BATCH_BITS-1:0]  batch_reg;
    logic [BATCH_BITS-1:0]  lim;
    logic                   cmd_valid, cmd_ready, q_empty, eng_idle;
    cmd_t                   cmd;
    logic [HANDLE_BITS-1:0] o_handle;
    logic [TIME_BITS-1:0]   o_deadline;

    // APB register: batch_limit, written on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BATCH) ? {27'd0, batch_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= BATCH_BITS'(MAX_BATCH);
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_BATCH)
        begin
            batch_reg <= pwdata[BATCH_BITS-1:0];
        end
    end

    // zero acts as one, anything over the maximum as the maximum
    always_comb
    begin
        if (batch_reg == '0)
        begin
            lim = BATCH_BITS'(1);
        end
        else if (batch_reg > BATCH_BITS'(MAX_BATCH))
        begin
            lim = BATCH_BITS'(MAX_BATCH);
        end
        else
        begin
            lim = batch_reg;
        end
    end

    ihtq_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_func     (s_tuser),
        .in_handle   (s_tdata[3:0]),
        .in_deadline (s_tdata[51:4]),
        .in_cut      (s_tdata[99:52]),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .q_empty     (q_empty)
    );

    ihtq_engine #(.HEAP_DEPTH(HEAP_DEPTH), .KEY_BITS(KEY_BITS)) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .lim          (lim),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (m_tuser),
        .out_handle   (o_handle),
        .out_deadline (o_deadline),
        .out_last     (m_tlast),
        .idle         (eng_idle)
    );

    assign m_tdata = {4'd0, o_deadline, o_handle};

    // nothing new can appear once the engine is idle with an empty queue
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && eng_idle && q_empty) |=> !m_tvalid)
        else $error("result word without a pending command");

    // only pops give non-final words, and those are always successful
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == ST_OK))
        else $error("non-final word with failure status");

    // failed results carry no entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == 56'd0))
        else $error("failed result carries data");
endmodule
`default_nettype wire

// ===== sv/ihtq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ihtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/ihtq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihtq_front
// Accepts input words, decodes the operation and queues commands (2 deep).
// ----------------------------------------------------------------------------
module ihtq_front
    import ihtq_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [1:0]   in_func,
    input  wire logic [3:0]   in_handle,
    input  wire logic [47:0]  in_deadline,
    input  wire logic [47:0]  in_cut,
    output logic              cmd_valid,
    input  wire logic         cmd_ready,
    output cmd_t              cmd,
    output logic              q_empty
);
    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       in_cmd;
    logic       push, pop;

    always_comb
    begin
        // every 2-bit code is a defined operation
        in_cmd.op       = op_t'(in_func);
        in_cmd.handle   = in_handle;
        in_cmd.deadline = in_deadline;
        in_cmd.cut      = in_cut;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign q_empty   = (cnt_reg == 2'd0);
    assign cmd       = mem_reg[rptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== sv/ihtq_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ihtq_engine
// Heap sequencer: sift up/down over the entry RAM, position table, results.
// ----------------------------------------------------------------------------
module ihtq_engine
    import ihtq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cmd_valid,
    output logic                       cmd_ready,
    input  wire cmd_t                  cmd,
    input  wire logic [BATCH_BITS-1:0] lim,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 out_status,
    output logic [HANDLE_BITS-1:0]     out_handle,
    output logic [TIME_BITS-1:0]       out_deadline,
    output logic                       out_last,
    output logic                       idle
);
    localparam int SW   = $clog2(HEAP_DEPTH);
    localparam int CNTW = $clog2(HEAP_DEPTH + 1);
    localparam int CW2  = SW + 2;
    localparam int EW   = KEY_BITS + HANDLE_BITS;
    localparam int CMPW = (KEY_BITS > TIME_BITS) ? KEY_BITS : TIME_BITS;

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_UP_CHK   = 15'h0002,
        S_UP_CMP   = 15'h0004,
        S_REM      = 15'h0008,
        S_REM_LAST = 15'h0010,
        S_REM_PAR  = 15'h0020,
        S_DN_CHK   = 15'h0040,
        S_DN_C0    = 15'h0080,
        S_DN_C1    = 15'h0100,
        S_DN_CMP   = 15'h0200,
        S_POP_RD   = 15'h0400,
        S_POP_CHK  = 15'h0800,
        S_POP_EMIT = 15'h1000,
        S_PEEK     = 15'h2000,
        S_FIN      = 15'h4000
    } state_t;

    state_t                  state_reg, state_next, done_state;
    op_t                     op_reg, op_next;
    logic [CNTW-1:0]         cnt_reg, cnt_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic [KEY_BITS-1:0]     car_key_reg, car_key_next;
    logic [HANDLE_BITS-1:0]  car_h_reg, car_h_next;
    logic [KEY_BITS-1:0]     ch_key_reg, ch_key_next;
    logic [HANDLE_BITS-1:0]  ch_h_reg, ch_h_next;
    logic [SW-1:0]           ch_idx_reg, ch_idx_next;
    logic [HANDLE_BITS-1:0]  rem_h_reg, rem_h_next;
    logic [BATCH_BITS-1:0]   n_reg, n_next;
    logic [TIME_BITS-1:0]    cut_reg, cut_next;
    status_t                 res_st_reg, res_st_next;
    logic [HANDLE_BITS-1:0]  res_h_reg, res_h_next;
    logic [KEY_BITS-1:0]     res_key_reg, res_key_next;
    logic                    res_have_reg, res_have_next;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_st_reg, out_st_next;
    logic [HANDLE_BITS-1:0]  out_h_reg, out_h_next;
    logic [TIME_BITS-1:0]    out_dl_reg, out_dl_next;
    logic                    out_last_reg, out_last_next;

    logic [SW-1:0]           pos_slot_reg [NUM_HANDLES];
    logic [NUM_HANDLES-1:0]  pos_v_reg;
    logic                    pos_we, pos_clr;
    logic [HANDLE_BITS-1:0]  pos_idx;
    logic [SW-1:0]           pos_val;

    logic                    ram_we;
    logic [SW-1:0]           ram_waddr, ram_raddr;
    logic [EW-1:0]           ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0]     rd_key;
    logic [HANDLE_BITS-1:0]  rd_h;
    logic [SW-1:0]           parent;
    logic [CW2-1:0]          child;
    logic                    can_out;
    logic [KEY_BITS-1:0]     in_key;

    ihtq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key     = ram_rdata[KEY_BITS-1:0];
    assign rd_h       = ram_rdata[EW-1:KEY_BITS];
    assign parent     = (slot_reg - SW'(1)) >> 1;
    assign child      = (CW2'(slot_reg) << 1) + CW2'(1);
    assign can_out    = !out_valid_reg || out_ready;
    assign in_key     = KEY_BITS'(cmd.deadline);
    assign done_state = (op_reg == OP_POP) ? S_POP_RD : S_FIN;
    assign idle       = (state_reg == S_IDLE);

    assign out_valid    = out_valid_reg;
    assign out_status   = out_st_reg;
    assign out_handle   = out_h_reg;
    assign out_deadline = out_dl_reg;
    assign out_last     = out_last_reg;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        car_key_next  = car_key_reg;
        car_h_next    = car_h_reg;
        ch_key_next   = ch_key_reg;
        ch_h_next     = ch_h_reg;
        ch_idx_next   = ch_idx_reg;
        rem_h_next    = rem_h_reg;
        n_next        = n_reg;
        cut_next      = cut_reg;
        res_st_next   = res_st_reg;
        res_h_next    = res_h_reg;
        res_key_next  = res_key_reg;
        res_have_next = res_have_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_st_next    = out_st_reg;
        out_h_next     = out_h_reg;
        out_dl_next    = out_dl_reg;
        out_last_next  = out_last_reg;
        cmd_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = {car_h_reg, car_key_reg};
        ram_raddr = '0;
        pos_we    = 1'b0;
        pos_clr   = 1'b0;
        pos_idx   = car_h_reg;
        pos_val   = slot_reg;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    op_next      = cmd.op;
                    res_h_next   = '0;
                    res_key_next = '0;
                    res_st_next  = ST_OK;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            if (pos_v_reg[cmd.handle])
                            begin
                                res_st_next = ST_HANDLE;
                                state_next  = S_FIN;
                            end
                            else if (cnt_reg == CNTW'(HEAP_DEPTH))
                            begin
                                res_st_next = ST_FULL;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                car_key_next = in_key;
                                car_h_next   = cmd.handle;
                                slot_next    = SW'(cnt_reg);
                                cnt_next     = cnt_reg + CNTW'(1);
                                state_next   = S_UP_CHK;
                            end
                        end
                        OP_ERASE:
                        begin
                            if (!pos_v_reg[cmd.handle] ||
                                CNTW'(pos_slot_reg[cmd.handle]) >= cnt_reg)
                            begin
                                res_st_next = ST_HANDLE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                slot_next  = pos_slot_reg[cmd.handle];
                                rem_h_next = cmd.handle;
                                state_next = S_REM;
                            end
                        end
                        OP_POP:
                        begin
                            cut_next      = cmd.cut;
                            n_next        = '0;
                            res_have_next = 1'b0;
                            state_next    = S_POP_RD;
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_st_next = ST_NONE;
                                state_next  = S_FIN;
                            end
                            else
                            begin
                                ram_raddr  = '0;
                                state_next = S_PEEK;
                            end
                        end
                    endcase
                end
            end
            S_UP_CHK:
            begin
                if (slot_reg == '0)
                begin
                    ram_we     = 1'b1;
                    pos_we     = 1'b1;
                    state_next = done_state;
                end
                else
                begin
                    ram_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP, S_REM_PAR:
            begin
                if (car_key_reg < rd_key)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = ram_rdata;
                    pos_we     = 1'b1;
                    pos_idx    = rd_h;
                    slot_next  = parent;
                    state_next = S_UP_CHK;
                end
                else if (state_reg == S_REM_PAR)
                begin
                    state_next = S_DN_CHK;
                end
                else
                begin
                    ram_we     = 1'b1;
                    pos_we     = 1'b1;
                    state_next = done_state;
                end
            end
            S_REM:
            begin
                pos_clr  = 1'b1;
                cnt_next = cnt_reg - CNTW'(1);
                if (CNTW'(slot_reg) == cnt_reg - CNTW'(1))
                begin
                    state_next = done_state;
                end
                else
                begin
                    ram_raddr  = SW'(cnt_reg - CNTW'(1));
                    state_next = S_REM_LAST;
                end
            end
            S_REM_LAST:
            begin
                car_key_next = rd_key;
                car_h_next   = rd_h;
                if (slot_reg != '0)
                begin
                    ram_raddr  = parent;
                    state_next = S_REM_PAR;
                end
                else
                begin
                    state_next = S_DN_CHK;
                end
            end
            S_DN_CHK:
            begin
                if (child < CW2'(cnt_reg))
                begin
                    ram_raddr  = SW'(child);
                    state_next = S_DN_C0;
                end
                else
                begin
                    ram_we     = 1'b1;
                    pos_we     = 1'b1;
                    state_next = done_state;
                end
            end
            S_DN_C0:
            begin
                ch_key_next = rd_key;
                ch_h_next   = rd_h;
                ch_idx_next = SW'(child);
                if (child + CW2'(1) < CW2'(cnt_reg))
                begin
                    ram_raddr  = SW'(child + CW2'(1));
                    state_next = S_DN_C1;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_C1:
            begin
                if (ch_key_reg > rd_key)
                begin
                    ch_key_next = rd_key;
                    ch_h_next   = rd_h;
                    ch_idx_next = SW'(child + CW2'(1));
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                ram_we = 1'b1;
                pos_we = 1'b1;
                if (ch_key_reg >= car_key_reg)
                begin
                    state_next = done_state;
                end
                else
                begin
                    ram_wdata  = {ch_h_reg, ch_key_reg};
                    pos_idx    = ch_h_reg;
                    slot_next  = ch_idx_reg;
                    state_next = S_DN_CHK;
                end
            end
            S_POP_RD:
            begin
                if (n_reg < lim && cnt_reg != '0)
                begin
                    ram_raddr  = '0;
                    state_next = S_POP_CHK;
                end
                else
                begin
                    if (!res_have_reg)
                    begin
                        res_st_next = ST_NONE;
                    end
                    state_next = S_FIN;
                end
            end
            S_POP_CHK:
            begin
                if (CMPW'(cut_reg) >= CMPW'(rd_key))
                begin
                    n_next       = n_reg + BATCH_BITS'(1);
                    slot_next    = '0;
                    rem_h_next   = rd_h;
                    car_key_next = rd_key;
                    car_h_next   = rd_h;
                    if (res_have_reg)
                    begin
                        state_next = S_POP_EMIT;
                    end
                    else
                    begin
                        res_have_next = 1'b1;
                        res_st_next   = ST_OK;
                        res_h_next    = rd_h;
                        res_key_next  = rd_key;
                        state_next    = S_REM;
                    end
                end
                else
                begin
                    if (!res_have_reg)
                    begin
                        res_st_next = ST_NONE;
                    end
                    state_next = S_FIN;
                end
            end
            S_POP_EMIT:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_h_next     = res_h_reg;
                    out_dl_next    = TIME_BITS'(res_key_reg);
                    out_last_next  = 1'b0;
                    res_h_next     = car_h_reg;
                    res_key_next   = car_key_reg;
                    state_next     = S_REM;
                end
            end
            S_PEEK:
            begin
                res_h_next   = rd_h;
                res_key_next = rd_key;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (can_out)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_h_next     = (res_st_reg == ST_OK) ? res_h_reg : '0;
                    out_dl_next    = (res_st_reg == ST_OK) ? TIME_BITS'(res_key_reg) : '0;
                    out_last_next  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_slot_reg[pos_idx] <= pos_val;
        end
        op_reg      <= op_next;
        slot_reg    <= slot_next;
        car_key_reg <= car_key_next;
        car_h_reg   <= car_h_next;
        ch_key_reg  <= ch_key_next;
        ch_h_reg    <= ch_h_next;
        ch_idx_reg  <= ch_idx_next;
        rem_h_reg   <= rem_h_next;
        n_reg       <= n_next;
        cut_reg     <= cut_next;
        res_st_reg  <= res_st_next;
        res_h_reg   <= res_h_next;
        res_key_reg <= res_key_next;
        res_have_reg <= res_have_next;
        out_st_reg  <= out_st_next;
        out_h_reg   <= out_h_next;
        out_dl_reg  <= out_dl_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            pos_v_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (pos_clr)
            begin
                pos_v_reg[rem_h_reg] <= 1'b0;
            end
            if (pos_we)
            begin
                pos_v_reg[pos_idx] <= 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== sim/indexed_min_heap_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue_tb
// Self-checking bench for the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
// A directed table covers reset behavior, extremes, error codes and ties, and
// random phases follow with mostly well-formed push/erase/pop/peek traffic
// over a small handle space. A heap model in the bench predicts every master
// word; words are compared in order. batch_limit is changed between phases
// while the queue is idle, including 0, 1, 16 and 31.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue_tb;
    import ihtq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int ABSENT    = 31;
    localparam int LIMIT_CYC = 400000;

    typedef struct packed {
        status_t     st;
        logic [3:0]  hdl;
        logic [47:0] dl;
        logic        lst;
    } word_t;

    typedef struct {
        op_t         op;
        logic [3:0]  hdl;
        logic [47:0] dl;
        logic [47:0] cut;
        bit          fixed;  // expected word typed in below
        word_t       want;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    indexed_min_heap_timer_queue DUT (.*);

    always #10 clk = ~clk;

    // bench copy of the heap
    logic [47:0] mkey [DEPTH];
    logic [3:0]  mhdl [DEPTH];
    int          mpos [16];
    int          mcount;
    int          mbatch;

    word_t       pending_words[$];
    int          errors = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          words_seen = 0;
    int          pops_seen = 0;
    bit          quiet_tail = 1'b0;
    bit          stall_rx = 1'b0;

    function automatic void heap_place(int s, logic [47:0] k, logic [3:0] h);
        mkey[s] = k;
        mhdl[s] = h;
        mpos[h] = s;
    endfunction

    function automatic void heap_up(int s, logic [47:0] k, logic [3:0] h);
        int p;
        while (s > 0)
        begin
            p = (s - 1) / 2;
            if (k >= mkey[p]) break;
            heap_place(s, mkey[p], mhdl[p]);
            s = p;
        end
        heap_place(s, k, h);
    endfunction

    function automatic void heap_down(int s, logic [47:0] k, logic [3:0] h);
        int c;
        c = 2 * s + 1;
        while (c < mcount)
        begin
            if (c + 1 < mcount && mkey[c] > mkey[c+1]) c++;
            if (mkey[c] >= k) break;
            heap_place(s, mkey[c], mhdl[c]);
            s = c;
            c = 2 * s + 1;
        end
        heap_place(s, k, h);
    endfunction

    function automatic void heap_remove(int s);
        mpos[mhdl[s]] = ABSENT;
        mcount--;
        if (s == mcount) return;
        if (s > 0 && mkey[mcount] < mkey[(s-1)/2])
            heap_up(s, mkey[mcount], mhdl[mcount]);
        else
            heap_down(s, mkey[mcount], mhdl[mcount]);
    endfunction

    function automatic word_t mk(status_t st, logic [3:0] h, logic [47:0] d, logic l);
        word_t w;
        w.st = st; w.hdl = h; w.dl = d; w.lst = l;
        return w;
    endfunction

    // predicts the words one command produces and queues them
    function automatic void predict_cmd(op_t op, logic [3:0] h, logic [47:0] d,
                                        logic [47:0] cut);
        int lim;
        int n;
        case (op)
            OP_PUSH:
            begin
                if (mpos[h] != ABSENT) pending_words.push_back(mk(ST_HANDLE, 0, 0, 1));
                else if (mcount >= DEPTH) pending_words.push_back(mk(ST_FULL, 0, 0, 1));
                else
                begin
                    mcount++;
                    heap_up(mcount - 1, d, h);
                    pending_words.push_back(mk(ST_OK, 0, 0, 1));
                end
            end
            OP_ERASE:
            begin
                if (mpos[h] == ABSENT) pending_words.push_back(mk(ST_HANDLE, 0, 0, 1));
                else
                begin
                    heap_remove(mpos[h]);
                    pending_words.push_back(mk(ST_OK, 0, 0, 1));
                end
            end
            OP_POP:
            begin
                lim = (mbatch == 0) ? 1 : (mbatch > MAX_BATCH ? MAX_BATCH : mbatch);
                n = 0;
                while (n < lim && mcount > 0 && cut >= mkey[0])
                begin
                    pending_words.push_back(mk(ST_OK, mhdl[0], mkey[0], 0));
                    heap_remove(0);
                    n++;
                end
                if (n == 0) pending_words.push_back(mk(ST_NONE, 0, 0, 1));
                else pending_words[$].lst = 1'b1;
            end
            default:
            begin
                if (mcount == 0) pending_words.push_back(mk(ST_NONE, 0, 0, 1));
                else pending_words.push_back(mk(ST_OK, mhdl[0], mkey[0], 1));
            end
        endcase
    endfunction

    // output checker
    always @(posedge clk)
    begin
        word_t got;
        word_t exp_w;
        cycles <= cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = mk(status_t'(m_tuser), m_tdata[3:0], m_tdata[51:4], m_tlast);
            words_seen <= words_seen + 1;
            if (pending_words.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10) $display("unexpected word %p", got);
            end
            else
            begin
                exp_w = pending_words.pop_front();
                if (got !== exp_w)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: expected %p, got %p", exp_w, got);
                end
                else if (exp_w.hdl != 0 || exp_w.dl != 0) pops_seen <= pops_seen + 1;
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (quiet_tail) m_tready <= 1'b1;
        else if (stall_rx) m_tready <= 1'b0;
        else if ($urandom_range(0, 5) == 0) m_tready <= 1'b0;
        else m_tready <= 1'b1;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                stall_rx = 1'b1;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                stall_rx = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > LIMIT_CYC)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write(logic [31:0] v);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_BATCH; pwdata <= v;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mbatch = v & 31;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // drives one command and predicts it at acceptance; tvalid stays high so
    // the next command can follow without a gap
    task automatic send_cmd(op_t op, logic [3:0] h, logic [47:0] d, logic [47:0] cut);
        if (!quiet_tail && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'd0, cut, d, h};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_cmd(op, h, d, cut);
        @(negedge clk);
    endtask

    function automatic logic [47:0] rnd48();
        return 48'({$urandom(), $urandom()});
    endfunction

    row_t rows[$];
    localparam logic [47:0] MAXT = 48'hFFFF_FFFF_FFFF;

    function automatic row_t r(op_t op, logic [3:0] h, logic [47:0] d, logic [47:0] c,
                               bit fx = 0, word_t w = '0);
        row_t x;
        x.op = op; x.hdl = h; x.dl = d; x.cut = c; x.fixed = fx; x.want = w;
        return x;
    endfunction

    initial
    begin
        int k;
        int sel;
        logic [3:0] h;
        int lims[5];
        lims = '{1, 0, 31, 4, 16};
        for (int i = 0; i < 16; i++) mpos[i] = ABSENT;
        mcount = 0;
        mbatch = 16;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        rows.push_back(r(OP_PEEK, 0, 0, 0, 1, mk(ST_NONE, 0, 0, 1)));
        rows.push_back(r(OP_POP, 0, 0, MAXT, 1, mk(ST_NONE, 0, 0, 1)));
        rows.push_back(r(OP_ERASE, 15, 0, 0, 1, mk(ST_HANDLE, 0, 0, 1)));
        rows.push_back(r(OP_PUSH, 15, MAXT, 0, 1, mk(ST_OK, 0, 0, 1)));
        rows.push_back(r(OP_PUSH, 15, 5, 0, 1, mk(ST_HANDLE, 0, 0, 1)));
        rows.push_back(r(OP_PEEK, 0, 0, 0, 1, mk(ST_OK, 15, MAXT, 1)));
        rows.push_back(r(OP_PUSH, 0, 0, 0, 1, mk(ST_OK, 0, 0, 1)));
        rows.push_back(r(OP_PEEK, 0, 0, 0, 1, mk(ST_OK, 0, 0, 1)));
        rows.push_back(r(OP_PUSH, 3, 100, 0));
        rows.push_back(r(OP_PUSH, 4, 100, 0));  // tie with handle 3
        rows.push_back(r(OP_PUSH, 5, 50, 0));
        rows.push_back(r(OP_ERASE, 0, 0, 0));
        rows.push_back(r(OP_POP, 0, 0, 49));
        rows.push_back(r(OP_POP, 0, 0, 100));
        rows.push_back(r(OP_POP, 0, 0, MAXT - 1));
        rows.push_back(r(OP_POP, 0, 0, MAXT));
        for (int i = 0; i < 17; i++)       // fill every handle, then push one again
            rows.push_back(r(OP_PUSH, i[3:0], 48'(17 - i), 0));
        foreach (rows[i])
        begin
            if (rows[i].fixed)
            begin
                send_cmd(rows[i].op, rows[i].hdl, rows[i].dl, rows[i].cut);
                pending_words[$] = rows[i].want;   // typed value replaces prediction
            end
            else send_cmd(rows[i].op, rows[i].hdl, rows[i].dl, rows[i].cut);
        end
        // sender holds off until the queue drains
        wait_idle();
        send_cmd(OP_PUSH, 7, 1, 0);   // duplicate beats full
        send_cmd(OP_POP, 0, 0, MAXT);

        // random phases over several batch limits
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            apb_write(lims[p]);
            if (p == 4) quiet_tail = 1'b1;
            for (int n = 0; n < 35; n++)
            begin
                sel = $urandom_range(0, 99);
                h = (n % 3 == 0) ? 4'($urandom()) : 4'($urandom_range(0, 7));
                if (sel < 45)
                    send_cmd(OP_PUSH, h,
                             ($urandom_range(0, 9) == 0) ? rnd48() : 48'($urandom_range(0, 60)), 0);
                else if (sel < 60) send_cmd(OP_ERASE, h, 0, 0);
                else if (sel < 85)
                    send_cmd(OP_POP, 0, 0,
                             ($urandom_range(0, 9) == 0) ? rnd48() : 48'($urandom_range(0, 70)));
                else send_cmd(OP_PEEK, h, rnd48(), rnd48());
            end
        end
        s_tvalid <= 1'b0;
        k = 0;
        while (pending_words.size() != 0 && k < 20000)
        begin
            @(negedge clk);
            k++;
        end
        repeat (100) @(negedge clk);
        $display("covered push, erase, pop and peek under five batch limits");
        $display("%0d words checked, %0d carrying an entry", words_seen, pops_seen);
        if (errors == 0 && pending_words.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
